// ===== rtl/core/swmmm_pkg.sv =====
`default_nettype none

package swmmm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AXES     = 3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic accept;
        logic prime;
        logic scan;
        logic div_load;
        logic div_step;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] min;
        logic signed [SAMPLE_W-1:0] max;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/swmmm_div.sv =====
`default_nettype none

module swmmm_div #(
    parameter int SUM_W   = 21,
    parameter int DIVISOR = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 load,
    input  wire logic                                 step,
    input  wire logic signed [SUM_W-1:0]              dividend,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]     quotient
);
    import swmmm_pkg::*;

    // The magnitude of the sum stays below 2**SUM_W, so a reciprocal rounded up with
    // SUM_W + clog2(DIVISOR) fraction bits gives the exact truncated quotient.
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [SUM_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic signed [SAMPLE_W-1:0] q_reg, q_next;
    logic [PROD_W-1:0]          prod;
    logic [SAMPLE_W-1:0]        q_mag;

    assign prod  = PROD_W'(mag_reg) * PROD_W'(RECIP);
    assign q_mag = prod[SHIFT +: SAMPLE_W];

    always_comb begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        q_next   = q_reg;
        if (load) begin
            neg_next = dividend[SUM_W-1];
            mag_next = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
        end else if (step) begin
            q_next = neg_reg ? $signed(~q_mag + 1'b1) : $signed(q_mag);
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swmmm_lane.sv =====
`default_nettype none

module swmmm_lane #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                                 aclk,
    input  wire swmmm_pkg::lane_ctl_t                 ctl,
    input  wire logic signed [swmmm_pkg::SAMPLE_W-1:0] sample,
    output swmmm_pkg::lane_res_t                      res
);
    import swmmm_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

    logic signed [SAMPLE_W-1:0] win_reg  [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] win_next [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] mean;

    // The oldest entry sits at the far end; a scan rotates it back to the front.
    assign tap = win_reg[WINDOW_DEPTH-1];

    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end
        if (ctl.prime) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_next[i] = sample;
            end
        end else if (ctl.accept || ctl.scan) begin
            win_next[0] = ctl.accept ? sample : tap;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    always_comb begin
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctl.accept) begin
            sum_next = '0;
            min_next = SAMPLE_MAX;
            max_next = SAMPLE_MIN;
        end else if (ctl.scan) begin
            sum_next = sum_reg + SUM_W'(tap);
            if (tap < min_reg) begin
                min_next = tap;
            end
            if (tap > max_reg) begin
                max_next = tap;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
        sum_reg <= sum_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    swmmm_div #(
        .SUM_W   (SUM_W),
        .DIVISOR (WINDOW_DEPTH)
    ) u_div (
        .aclk     (aclk),
        .load     (ctl.div_load),
        .step     (ctl.div_step),
        .dividend (sum_reg),
        .quotient (mean)
    );

    assign res.mean = mean;
    assign res.min  = min_reg;
    assign res.max  = max_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_min_max_mean_core.sv =====
// Channel  | Handshake           | Payload
// -------- | ------------------- | ----------------------------------------------
// input    | s_valid / s_ready   | s_sample_x, s_sample_y, s_sample_z
// result   | m_valid / m_ready   | m_mean_*, m_min_*, m_max_* (x, y, z)
//
// Each item passes through these steps from accept to accept: the block takes it,
// scans the window by rotating it through all WINDOW_DEPTH entries, latches the
// magnitude of the sum, does the reciprocal multiply that gives the mean and hands
// the result to the output register. The three axes run in parallel lanes.
// Reset is synchronous and active low.
// A new item is taken while the previous result still waits; a stall on the result
// channel holds the finished item in the engine.
`default_nettype none

module sliding_window_min_max_mean_core #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [swmmm_pkg::SAMPLE_W-1:0] s_sample_x,
    input  wire logic signed [swmmm_pkg::SAMPLE_W-1:0] s_sample_y,
    input  wire logic signed [swmmm_pkg::SAMPLE_W-1:0] s_sample_z,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_mean_x,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_mean_y,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_mean_z,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_min_x,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_min_y,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_min_z,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_max_x,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_max_y,
    output logic signed [swmmm_pkg::SAMPLE_W-1:0]      m_max_z
);
    import swmmm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       primed_reg;
    logic                       m_valid_reg;
    lane_ctl_t                  ctl;
    lane_res_t                  res [AXES];
    logic signed [SAMPLE_W-1:0] lane_sample [AXES];
    logic                       out_load;
    logic signed [SAMPLE_W-1:0] mean_reg [AXES];
    logic signed [SAMPLE_W-1:0] min_reg  [AXES];
    logic signed [SAMPLE_W-1:0] max_reg  [AXES];

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign ctl.accept   = s_valid && s_ready;
    assign ctl.prime    = s_valid && s_ready && !primed_reg;
    assign ctl.scan     = (state_reg == ST_SCAN);
    assign ctl.div_load = (state_reg == ST_DLOAD);
    assign ctl.div_step = (state_reg == ST_DIV);

    assign lane_sample[0] = s_sample_x;
    assign lane_sample[1] = s_sample_y;
    assign lane_sample[2] = s_sample_z;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        swmmm_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH)
        ) u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .sample (lane_sample[a]),
            .res    (res[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (ctl.accept) begin
                        primed_reg <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg == SCAN_LAST) begin
                        state_reg <= ST_DLOAD;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DLOAD: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (out_load) begin
            for (int a = 0; a < AXES; a++) begin
                mean_reg[a] <= res[a].mean;
                min_reg[a]  <= res[a].min;
                max_reg[a]  <= res[a].max;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_mean_x = mean_reg[0];
    assign m_mean_y = mean_reg[1];
    assign m_mean_z = mean_reg[2];
    assign m_min_x  = min_reg[0];
    assign m_min_y  = min_reg[1];
    assign m_min_z  = min_reg[2];
    assign m_max_x  = max_reg[0];
    assign m_max_y  = max_reg[1];
    assign m_max_z  = max_reg[2];

endmodule

`default_nettype wire

// ===== rtl/core/swmmm_chk.sv =====
`default_nettype none

module swmmm_chk (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_mean_x,
    input wire logic signed [15:0] m_mean_y,
    input wire logic signed [15:0] m_mean_z,
    input wire logic signed [15:0] m_min_x,
    input wire logic signed [15:0] m_min_y,
    input wire logic signed [15:0] m_min_z,
    input wire logic signed [15:0] m_max_x,
    input wire logic signed [15:0] m_max_y,
    input wire logic signed [15:0] m_max_z
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_x) && $stable(m_min_y)
            && $stable(m_max_z))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_order_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_x <= m_mean_x) && (m_mean_x <= m_max_x))
        else $error("x mean outside window min and max");

    a_order_yz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_y <= m_mean_y) && (m_mean_y <= m_max_y)
            && (m_min_z <= m_mean_z) && (m_mean_z <= m_max_z))
        else $error("y or z mean outside window min and max");

endmodule

bind sliding_window_min_max_mean_core swmmm_chk u_swmmm_chk (.*);

`default_nettype wire

// ===== test/tb_sliding_window_min_max_mean_core.sv =====
`default_nettype none

module tb_sliding_window_min_max_mean_core;
    import swmmm_pkg::*;

    localparam int DEPTH       = 32;
    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 1130;
    localparam int N_ITEMS     = N_DIRECTED + N_RANDOM;
    localparam int CYCLE_LIMIT = 800000;

    typedef lane_res_t [AXES-1:0] stats_t;

    logic                       aclk       = 1'b0;
    logic                       aresetn    = 1'b0;
    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_x = '0;
    logic signed [SAMPLE_W-1:0] s_sample_y = '0;
    logic signed [SAMPLE_W-1:0] s_sample_z = '0;
    logic                       m_valid;
    logic                       m_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] m_mean_x, m_mean_y, m_mean_z;
    logic signed [SAMPLE_W-1:0] m_min_x, m_min_y, m_min_z;
    logic signed [SAMPLE_W-1:0] m_max_x, m_max_y, m_max_z;

    stats_t                     pending_stats[$];
    logic signed [SAMPLE_W-1:0] window_copy [0:DEPTH-1][0:AXES-1];
    bit                         window_primed = 1'b0;
    int                         mismatches    = 0;
    int                         send_idle_pct = 21;
    int                         recv_idle_pct = 46;
    int                         cycle_count   = 0;
    logic [3*SAMPLE_W:0]        sample_table [0:N_DIRECTED-1];

    sliding_window_min_max_mean_core #(
        .WINDOW_DEPTH(DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample_x(s_sample_x),
        .s_sample_y(s_sample_y),
        .s_sample_z(s_sample_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mean_x  (m_mean_x),
        .m_mean_y  (m_mean_y),
        .m_mean_z  (m_mean_z),
        .m_min_x   (m_min_x),
        .m_min_y   (m_min_y),
        .m_min_z   (m_min_z),
        .m_max_x   (m_max_x),
        .m_max_y   (m_max_y),
        .m_max_z   (m_max_z)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Shifts one sample into the window copy (the first fills all of it); returns mean, min and max per axis.
    function automatic stats_t window_stats_after(logic signed [SAMPLE_W-1:0] x,
                                                  logic signed [SAMPLE_W-1:0] y,
                                                  logic signed [SAMPLE_W-1:0] z);
        logic signed [SAMPLE_W-1:0] s [0:AXES-1];
        logic signed [SAMPLE_W-1:0] lo, hi;
        stats_t                     r;
        int                         sum, i, a;
        s[0] = x;
        s[1] = y;
        s[2] = z;
        if (!window_primed) begin
            for (i = 0; i < DEPTH; i++) begin
                for (a = 0; a < AXES; a++) window_copy[i][a] = s[a];
            end
            window_primed = 1'b1;
        end else begin
            for (i = DEPTH - 1; i > 0; i--) begin
                for (a = 0; a < AXES; a++) window_copy[i][a] = window_copy[i-1][a];
            end
            for (a = 0; a < AXES; a++) window_copy[0][a] = s[a];
        end
        for (a = 0; a < AXES; a++) begin
            sum = 0;
            lo  = SAMPLE_MAX;
            hi  = SAMPLE_MIN;
            for (i = 0; i < DEPTH; i++) begin
                sum += window_copy[i][a];
                if (window_copy[i][a] < lo) lo = window_copy[i][a];
                if (window_copy[i][a] > hi) hi = window_copy[i][a];
            end
            r[a].mean = SAMPLE_W'(sum / DEPTH);
            r[a].min  = lo;
            r[a].max  = hi;
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_axis(int kind, logic [SAMPLE_W-1:0] prev);
        logic [SAMPLE_W-1:0] v;
        case (kind)
            5: v = SAMPLE_W'($urandom_range(32) - 16);
            6: begin
                case ($urandom_range(3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            7, 8: v = prev;
            9: v = 16'h7FFF - SAMPLE_W'($urandom_range(255));
            10: v = 16'h8000 + SAMPLE_W'($urandom_range(255));
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    initial begin : sender
        logic [SAMPLE_W-1:0] sx, sy, sz;
        stats_t              want;
        int                  k, gap;
        sample_table[0]  = {1'b1, 16'h8000, 16'h7FFF, 16'h0000};
        sample_table[1]  = {1'b0, 16'h7FFF, 16'h8000, 16'hFFFF};
        sample_table[2]  = {1'b0, 16'h0000, 16'h0000, 16'h0000};
        sample_table[3]  = {1'b0, 16'hFFFF, 16'h0001, 16'h5555};
        sample_table[4]  = {1'b0, 16'hAAAA, 16'h5555, 16'hAAAA};
        sample_table[5]  = {1'b0, 16'h8000, 16'h8000, 16'h8000};
        sample_table[6]  = {1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        sample_table[7]  = {1'b0, 16'h8001, 16'h7FFE, 16'h0001};
        sample_table[8]  = {1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        sample_table[9]  = {1'b0, 16'hFFFE, 16'h0002, 16'hFFE0};
        sample_table[10] = {1'b0, 16'h0100, 16'hFF00, 16'h0020};
        sample_table[11] = {1'b0, 16'h8000, 16'h7FFF, 16'h8000};
        sample_table[12] = {1'b0, 16'h8000, 16'h7FFF, 16'h8000};
        sample_table[13] = {1'b0, 16'h1234, 16'hEDCB, 16'h0F0F};
        sample_table[14] = {1'b0, 16'hF0F0, 16'h0F0F, 16'hF0F0};
        sample_table[15] = {1'b0, 16'h0001, 16'hFFFF, 16'h0000};
        sample_table[16] = {1'b0, 16'hFFE1, 16'h001F, 16'hFFE0};
        sample_table[17] = {1'b0, 16'h7FFF, 16'h8000, 16'h7FFF};
        sample_table[18] = {1'b0, 16'h4000, 16'hC000, 16'h3FFF};
        sample_table[19] = {1'b0, 16'hC001, 16'h4001, 16'hBFFF};
        sx = '0;
        sy = '0;
        sz = '0;
        do @(posedge aclk); while (!aresetn);
        for (k = 0; k < N_ITEMS; k++) begin
            if (k < N_ITEMS / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 46;
            end else if (k < 2 * N_ITEMS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (k < N_DIRECTED) begin
                sx = sample_table[k][47:32];
                sy = sample_table[k][31:16];
                sz = sample_table[k][15:0];
            end else begin
                sx = random_axis($urandom_range(10), sx);
                sy = random_axis($urandom_range(10), sy);
                sz = random_axis($urandom_range(10), sz);
            end
            gap = 0;
            while ($urandom_range(99) < send_idle_pct) gap++;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid    <= 1'b1;
            s_sample_x <= sx;
            s_sample_y <= sy;
            s_sample_z <= sz;
            do @(posedge aclk); while (!s_ready);
            want = window_stats_after(sx, sy, sz);
            if (k < N_DIRECTED && sample_table[k][48]) begin
                // The first item primes the whole window, so all three statistics equal it.
                want[0] = {sx, sx, sx};
                want[1] = {sy, sy, sy};
                want[2] = {sz, sz, sz};
            end
            pending_stats.push_back(want);
        end
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (4 * DEPTH) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge aclk) begin : receiver
        stats_t got, want;
        int     a;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got[0] = {m_mean_x, m_min_x, m_max_x};
                got[1] = {m_mean_y, m_min_y, m_max_y};
                got[2] = {m_mean_z, m_min_z, m_max_z};
                if (pending_stats.size() == 0) begin
                    $display("%0t: result arrived with no item pending", $time);
                    mismatches++;
                end else begin
                    want = pending_stats.pop_front();
                    for (a = 0; a < AXES; a++) begin
                        if (got[a].mean !== want[a].mean) begin
                            $display("%0t: mean_%s expected %0d, got %0d", $time,
                                     a == 0 ? "x" : a == 1 ? "y" : "z",
                                     want[a].mean, got[a].mean);
                            mismatches++;
                        end
                        if (got[a].min !== want[a].min) begin
                            $display("%0t: min_%s expected %0d, got %0d", $time,
                                     a == 0 ? "x" : a == 1 ? "y" : "z",
                                     want[a].min, got[a].min);
                            mismatches++;
                        end
                        if (got[a].max !== want[a].max) begin
                            $display("%0t: max_%s expected %0d, got %0d", $time,
                                     a == 0 ? "x" : a == 1 ? "y" : "z",
                                     want[a].max, got[a].max);
                            mismatches++;
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== sliding_window_min_max_mean_core.f =====
rtl/core/swmmm_pkg.sv
rtl/core/swmmm_div.sv
rtl/core/swmmm_lane.sv
rtl/core/sliding_window_min_max_mean_core.sv
rtl/core/swmmm_chk.sv
test/tb_sliding_window_min_max_mean_core.sv
